// ----- rtl/hpb_pkg.sv -----
`default_nettype none
package hpb_pkg;

  localparam logic signed [23:0] COEF_A = 24'sd3089397;
  localparam logic signed [23:0] COEF_B = 24'sd6178793;
  localparam logic [31:0] KCOEF_Q36 = 32'd287851471;
  localparam int HEAD_MAX = 12868;
  localparam int ELEV_MAX = 6434;
  localparam int PI_Q16 = 205887;
  localparam int CORDIC_ITERS = 17;

  localparam logic CFG_SAMPLE_RATE = 1'b0;
  localparam logic CFG_FFT_SIZE = 1'b1;

  typedef struct packed {
    logic signed [14:0] heading;
    logic signed [31:0] xq;
    logic signed [31:0] yq;
    logic [31:0]        f8;
  } hpb_job_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0: v = 17'd51472;
      5'd1: v = 17'd30386;
      5'd2: v = 17'd16055;
      5'd3: v = 17'd8150;
      5'd4: v = 17'd4091;
      5'd5: v = 17'd2047;
      5'd6: v = 17'd1024;
      5'd7: v = 17'd512;
      5'd8: v = 17'd256;
      5'd9: v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hpb_cordic.sv -----
`default_nettype none
// Iterative vectoring CORDIC: one micro-rotation per cycle, Q12 result.
module hpb_cordic
  import hpb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [33:0] y_in,
  input  wire logic signed [33:0] x_in,
  output logic                    done,
  output logic signed [14:0]      angle
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_DONE = 3'b100
  } cst_t;

  cst_t state_r, state_nxt;
  logic signed [59:0] x_r, y_r;
  logic signed [59:0] x_nxt, y_nxt;
  logic signed [20:0] z_r, z_nxt;
  logic signed [19:0] off_r, off_nxt;
  logic [4:0] it_r, it_nxt;
  logic zero_r, zero_nxt;
  logic signed [59:0] xs, ys, dx, dy;
  logic signed [21:0] sum;
  logic signed [17:0] res;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign xs = 60'(x_in) <<< 24;
  assign ys = 60'(y_in) <<< 24;
  assign sum = 22'(off_r) + 22'(z_r) + 22'sd8;
  assign res = 18'(sum >>> 4);

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    off_nxt = off_r;
    it_nxt = it_r;
    zero_nxt = zero_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          zero_nxt = (x_in == 34'sd0) && (y_in == 34'sd0);
          z_nxt = '0;
          it_nxt = '0;
          if (xs < 0) begin
            off_nxt = (ys >= 0) ? 20'(PI_Q16) : -20'(PI_Q16);
            x_nxt = -xs;
            y_nxt = -ys;
          end else begin
            off_nxt = '0;
            x_nxt = xs;
            y_nxt = ys;
          end
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        if (y_r >= 0) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + 21'(atan_q16(it_r));
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - 21'(atan_q16(it_r));
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(CORDIC_ITERS - 1)) state_nxt = C_DONE;
      end
      C_DONE: state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else state_r <= state_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    off_r <= off_nxt;
    it_r <= it_nxt;
    zero_r <= zero_nxt;
  end

  assign done = (state_r == C_DONE);

  always_comb begin
    if (zero_r) angle = '0;
    else if (res > 18'(HEAD_MAX)) angle = 15'(HEAD_MAX);
    else if (res < -18'(HEAD_MAX)) angle = -15'(HEAD_MAX);
    else angle = 15'(res);
  end

endmodule
`default_nettype wire

// ----- rtl/hpb_front.sv -----
`default_nettype none
// Front end: geometry matrix, bin-to-frequency divide, heading CORDIC (mode 0; mode 1 passes the given values on).
module hpb_front
  import hpb_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [23:0]        adc_rate_hz,
  input  wire logic [16:0]        fft_size,
  input  wire logic               action,
  input  wire logic signed [15:0] phase_ref,
  input  wire logic signed [15:0] phase_a,
  input  wire logic signed [15:0] phase_b,
  input  wire logic signed [15:0] phase_c,
  input  wire logic [15:0]        bin_index,
  input  wire logic signed [14:0] given_heading,
  input  wire logic signed [31:0] given_x,
  input  wire logic signed [31:0] given_y,
  input  wire logic [23:0]        given_frequency,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output hpb_job_t                job
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL  = 6'b000010,
    F_SUM  = 6'b000100,
    F_DIV  = 6'b001000,
    F_ATAN = 6'b010000,
    F_OUT  = 6'b100000
  } fst_t;

  fst_t state_r;
  logic signed [16:0] da_r, db_r, dc_r;
  logic [15:0] bin_r;
  logic signed [41:0] pa_r, pb_r, pc_r;
  logic signed [44:0] accx, accy;
  logic signed [44:0] half;
  logic signed [44:0] rx, ry;
  logic [47:0] num_r;
  logic [48:0] rem_r;
  logic [5:0] dcnt_r;
  logic [47:0] quo_r;
  logic [49:0] rem_sh;
  logic [39:0] prod;
  hpb_job_t job_r;
  logic cord_start;
  logic cord_done;
  logic signed [14:0] cord_angle;
  logic zero_div_r;

  assign half = 45'sd1 <<< (PHASE_FRAC_BITS - 1);
  assign accx = 45'(pa_r) - 45'(pb_r) + 45'(pc_r);
  assign accy = 45'(pc_r) - 45'(pa_r);
  assign rx = (accx + half) >>> PHASE_FRAC_BITS;
  assign ry = (accy + half) >>> PHASE_FRAC_BITS;
  assign prod = 40'(bin_r) * 40'(adc_rate_hz);
  assign rem_sh = {rem_r, num_r[47]};

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    if (v > 45'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -45'sh80000000) return 32'sh80000000;
    return 32'(v);
  endfunction

  assign cord_start = (state_r == F_DIV) && (dcnt_r == 6'd0);

  hpb_cordic u_atan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .y_in  (34'(job_r.yq)),
    .x_in  (34'(job_r.xq)),
    .done  (cord_done),
    .angle (cord_angle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            da_r <= 17'(phase_a) - 17'(phase_ref);
            db_r <= 17'(phase_b) - 17'(phase_ref);
            dc_r <= 17'(phase_c) - 17'(phase_ref);
            bin_r <= bin_index;
            job_r.heading <= given_heading;
            job_r.xq <= given_x;
            job_r.yq <= given_y;
            job_r.f8 <= {given_frequency, 8'd0};
            state_r <= action ? F_OUT : F_MUL;
          end
        end
        F_MUL: begin
          pa_r <= 42'(da_r) * 42'(COEF_A);
          pb_r <= 42'(db_r) * 42'(COEF_B);
          pc_r <= 42'(dc_r) * 42'(COEF_A);
          state_r <= F_SUM;
        end
        F_SUM: begin
          job_r.xq <= sat32(rx);
          job_r.yq <= sat32(ry);
          num_r <= {prod, 8'd0};
          rem_r <= '0;
          quo_r <= '0;
          dcnt_r <= 6'd48;
          zero_div_r <= (fft_size == 17'd0);
          state_r <= F_DIV;
        end
        F_DIV: begin
          if (dcnt_r != 6'd0) begin
            // restoring divide, one quotient bit per cycle
            num_r <= num_r << 1;
            if (rem_sh >= 50'(fft_size)) begin
              rem_r <= 49'(rem_sh - 50'(fft_size));
              quo_r <= {quo_r[46:0], 1'b1};
            end else begin
              rem_r <= 49'(rem_sh);
              quo_r <= {quo_r[46:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 6'd1;
          end else begin
            if (zero_div_r || quo_r[47:32] != 16'd0) job_r.f8 <= 32'hFFFFFFFF;
            else job_r.f8 <= quo_r[31:0];
            state_r <= F_ATAN;
          end
        end
        F_ATAN: begin
          if (cord_done) begin
            job_r.heading <= cord_angle;
            state_r <= F_OUT;
          end
        end
        F_OUT: begin
          if (job_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign busy = (state_r != F_IDLE);
  assign job_valid = (state_r == F_OUT);
  assign job = job_r;

endmodule
`default_nettype wire

// ----- rtl/hpb_queue.sv -----
`default_nettype none
// Two-entry request queue between front and back.
module hpb_queue
  import hpb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  input  wire hpb_job_t wr_data,
  output logic          rd_valid,
  input  wire logic     rd_ready,
  output hpb_job_t      rd_data
);

  hpb_job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hpb_back.sv -----
`default_nettype none
// Back end: wavenumber, h, and unless flagged the elevation root and elevation CORDIC.
module hpb_back
  import hpb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire hpb_job_t      job,
  output logic               out_valid,
  output logic signed [14:0] out_heading,
  output logic [12:0]        out_elevation,
  output logic [23:0]        out_frequency,
  output logic               out_flag
);

  typedef enum logic [7:0] {
    B_IDLE  = 8'b00000001,
    B_MUL   = 8'b00000010,
    B_KSUM  = 8'b00000100,
    B_SQRT1 = 8'b00001000,
    B_SHIFT = 8'b00010000,
    B_SQRT2 = 8'b00100000,
    B_ATAN  = 8'b01000000,
    B_OUT   = 8'b10000000
  } bst_t;

  bst_t state_r;
  hpb_job_t j_r;
  logic [31:0] ax_r, ay_r;
  logic [63:0] xx_r, yy_r;
  logic [47:0] klo_r, khi_r;
  logic [35:0] k_r;
  logic [32:0] sq_q_r;
  logic [5:0] sq_n_r;
  logic [35:0] h_r;
  logic [31:0] ks_r, hs_r;
  logic flag_r;
  logic [12:0] elev_r;
  logic cord_start, cord_done;
  logic signed [14:0] cord_angle;
  logic [65:0] sq_in_r;
  logic [65:0] sq_rem_r;
  logic [67:0] sq_cur;
  logic [64:0] kprod;
  logic [36:0] kround;
  logic [5:0] sh;
  logic [64:0] rootarg;

  // sqrt: two radicand bits consumed per cycle, 33 steps
  assign sq_cur = {sq_rem_r, sq_in_r[65:64]};

  assign cord_start = (state_r == B_SQRT2) && (sq_n_r == 6'd0);

  hpb_cordic u_atan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .y_in  ({2'b00, hs_r}),
    .x_in  ({1'b0, sq_q_r}),
    .done  (cord_done),
    .angle (cord_angle)
  );

  assign kprod = 65'(klo_r) + (65'(khi_r) << 16);
  assign kround = 37'((kprod + 65'd134217728) >> 28);

  always_comb begin
    sh = '0;
    for (int s = 0; s < 6; s++) begin
      if ((k_r >> sh) >= 36'h80000000) sh = sh + 6'd1;
    end
  end

  assign rootarg = 65'(64'(ks_r - hs_r) * 64'(ks_r + hs_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            j_r <= job;
            ax_r <= job.xq[31] ? 32'(-job.xq) : 32'(job.xq);
            ay_r <= job.yq[31] ? 32'(-job.yq) : 32'(job.yq);
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          xx_r <= 64'(ax_r) * 64'(ax_r);
          yy_r <= 64'(ay_r) * 64'(ay_r);
          klo_r <= 48'(j_r.f8[15:0]) * 48'(KCOEF_Q36);
          khi_r <= 48'(j_r.f8[31:16]) * 48'(KCOEF_Q36);
          state_r <= B_KSUM;
        end
        B_KSUM: begin
          k_r <= 36'(kround);
          sq_in_r <= 66'(xx_r) + 66'(yy_r);
          sq_rem_r <= '0;
          sq_q_r <= '0;
          sq_n_r <= 6'd33;
          state_r <= B_SQRT1;
        end
        B_SQRT1: begin
          if (sq_n_r != 6'd0) begin
            sq_in_r <= sq_in_r << 2;
            if (sq_cur >= {33'd0, sq_q_r, 2'b01}) begin
              sq_rem_r <= 66'(sq_cur - {33'd0, sq_q_r, 2'b01});
              sq_q_r <= {sq_q_r[31:0], 1'b1};
            end else begin
              sq_rem_r <= 66'(sq_cur);
              sq_q_r <= {sq_q_r[31:0], 1'b0};
            end
            sq_n_r <= sq_n_r - 6'd1;
          end else begin
            h_r <= 36'(sq_q_r);
            state_r <= B_SHIFT;
          end
        end
        B_SHIFT: begin
          flag_r <= (k_r == 36'd0) || (k_r < h_r);
          ks_r <= 32'(k_r >> sh);
          hs_r <= 32'(h_r >> sh);
          state_r <= B_SQRT2;
          sq_n_r <= 6'd34;
        end
        B_SQRT2: begin
          if (flag_r) begin
            elev_r <= '0;
            state_r <= B_OUT;
          end else if (sq_n_r == 6'd34) begin
            sq_in_r <= {1'b0, rootarg};
            sq_rem_r <= '0;
            sq_q_r <= '0;
            sq_n_r <= 6'd33;
          end else if (sq_n_r != 6'd0) begin
            sq_in_r <= sq_in_r << 2;
            if (sq_cur >= {33'd0, sq_q_r, 2'b01}) begin
              sq_rem_r <= 66'(sq_cur - {33'd0, sq_q_r, 2'b01});
              sq_q_r <= {sq_q_r[31:0], 1'b1};
            end else begin
              sq_rem_r <= 66'(sq_cur);
              sq_q_r <= {sq_q_r[31:0], 1'b0};
            end
            sq_n_r <= sq_n_r - 6'd1;
          end else begin
            state_r <= B_ATAN;
          end
        end
        B_ATAN: begin
          if (cord_done) begin
            if (cord_angle < 0) elev_r <= '0;
            else if (cord_angle > 15'(ELEV_MAX)) elev_r <= 13'(ELEV_MAX);
            else elev_r <= 13'(cord_angle);
            state_r <= B_OUT;
          end
        end
        B_OUT: state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign job_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_heading = j_r.heading;
  assign out_elevation = elev_r;
  assign out_frequency = j_r.f8[31:8];
  assign out_flag = flag_r;

endmodule
`default_nettype wire

// ----- rtl/hydrophone_ping_bearing.sv -----
`default_nettype none
// Hydrophone ping bearing.
// Request channel: raise start with the in_ fields; the request is taken at
// a clock edge where start is high and busy is low. Mode 0 (in_action low)
// works from the four phases and the FFT bin, mode 1 from the given values.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 sample rate,
// 1 FFT size) and cfg_data; write only while no request is in flight.
// Results: out_valid is high for one cycle with heading, elevation,
// frequency and the out_of_range flag; the receiver cannot stall.
// Front end: a mode 0 request runs the matrix, the 48-step bin divide and the
// 17-step heading CORDIC before handoff; a mode 1 request goes straight to handoff.
// Back end: two 33-step square roots and the 17-step elevation CORDIC per
// request, with the second root and CORDIC skipped when flagged. A two-entry
// queue decouples the halves, so the sustained rate is set by the slower half.
// busy drops once the front end hands on.
// Reset (rst_n low, synchronous) empties both halves and the queue and
// loads sample rate 500000 and FFT size 256.
module hydrophone_ping_bearing
  import hpb_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic signed [15:0] in_phase_ref,
  input  wire logic signed [15:0] in_phase_a,
  input  wire logic signed [15:0] in_phase_b,
  input  wire logic signed [15:0] in_phase_c,
  input  wire logic [15:0]        in_bin_index,
  input  wire logic signed [14:0] in_given_heading,
  input  wire logic signed [31:0] in_given_x,
  input  wire logic signed [31:0] in_given_y,
  input  wire logic [23:0]        in_given_frequency,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic                    out_valid,
  output logic signed [14:0]      out_heading_out,
  output logic [12:0]             out_elevation_out,
  output logic [23:0]             out_frequency_hz,
  output logic                    out_out_of_range
);

  logic [23:0] adc_rate_r;
  logic [16:0] fft_size_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  hpb_job_t fj, bj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_rate_r <= 24'd500000;
      fft_size_r <= 17'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE: adc_rate_r <= cfg_data;
        CFG_FFT_SIZE: fft_size_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  hpb_front #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .adc_rate_hz     (adc_rate_r),
    .fft_size        (fft_size_r),
    .action          (in_action),
    .phase_ref       (in_phase_ref),
    .phase_a         (in_phase_a),
    .phase_b         (in_phase_b),
    .phase_c         (in_phase_c),
    .bin_index       (in_bin_index),
    .given_heading   (in_given_heading),
    .given_x         (in_given_x),
    .given_y         (in_given_y),
    .given_frequency (in_given_frequency),
    .job_valid       (fj_valid),
    .job_ready       (fj_ready),
    .job             (fj)
  );

  hpb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (bj)
  );

  hpb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (bj_valid),
    .job_ready     (bj_ready),
    .job           (bj),
    .out_valid     (out_valid),
    .out_heading   (out_heading_out),
    .out_elevation (out_elevation_out),
    .out_frequency (out_frequency_hz),
    .out_flag      (out_out_of_range)
  );

endmodule
`default_nettype wire

// ----- rtl/hpb_checker.sv -----
`default_nettype none
module hpb_checker
  import hpb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_out_of_range,
  input wire logic [12:0] out_elevation_out
);

  // a result is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");

  a_flag_elev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_elevation_out == 13'd0)
    else $error("flagged result with elevation");

  a_elev_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elevation_out <= 13'(ELEV_MAX))
    else $error("elevation beyond range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind hydrophone_ping_bearing hpb_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_out_of_range  (out_out_of_range),
  .out_elevation_out (out_elevation_out)
);
`default_nettype wire

// ----- bench/tb_hydrophone_ping_bearing.sv -----
module tb_hydrophone_ping_bearing;
  import hpb_pkg::*;

  localparam int FRAC = 12;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam longint unsigned F8_SAT = 64'hFFFF_FFFF;
  localparam longint ATAN_STEP [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic               action;
    logic signed [15:0] phase_ref;
    logic signed [15:0] phase_a;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_c;
    logic [15:0]        bin_index;
    logic signed [14:0] given_heading;
    logic signed [31:0] given_x;
    logic signed [31:0] given_y;
    logic [23:0]        given_frequency;
  } ping_t;

  typedef struct {
    logic [14:0] heading;
    logic [12:0] elevation;
    logic [23:0] frequency;
    logic        flag;
  } bearing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic signed [15:0] in_phase_ref = '0, in_phase_a = '0, in_phase_b = '0, in_phase_c = '0;
  logic [15:0] in_bin_index = '0;
  logic signed [14:0] in_given_heading = '0;
  logic signed [31:0] in_given_x = '0, in_given_y = '0;
  logic [23:0] in_given_frequency = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = CFG_SAMPLE_RATE;
  logic [23:0] cfg_data = '0;
  logic out_valid;
  logic signed [14:0] out_heading_out;
  logic [12:0] out_elevation_out;
  logic [23:0] out_frequency_hz;
  logic out_out_of_range;

  hydrophone_ping_bearing #(.PHASE_FRAC_BITS(FRAC)) DUT (.*);

  always #5 clk = ~clk;

  longint unsigned adc_rate = 500000;
  longint unsigned fft_len = 256;
  bearing_t pending_bearings[$];
  int fail_count = 0;
  int pings_sent = 0;
  int bearings_seen = 0;
  int flagged_seen = 0;
  int cfg_writes = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint xs, ys, z, off, res, dx, dy;
    z = 0;
    off = 0;
    if (x == 0 && y == 0) return 0;
    xs = x * 64'sd16777216;
    ys = y * 64'sd16777216;
    if (xs < 0) begin
      off = (ys >= 0) ? PI_Q16 : -PI_Q16;
      xs = -xs;
      ys = -ys;
    end
    for (int i = 0; i < 17; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx; ys -= dy; z += ATAN_STEP[i];
      end else begin
        xs -= dx; ys += dy; z -= ATAN_STEP[i];
      end
    end
    res = (off + z + 8) >>> 4;
    if (res > HEAD_MAX) res = HEAD_MAX;
    if (res < -HEAD_MAX) res = -HEAD_MAX;
    return res;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bearing_t predict_bearing(ping_t p);
    longint xq, yq, heading, elev, da, db, dc, accx, accy, ca, cb;
    longint unsigned f8, k, ax, ay, h, ks, hs, r, prod;
    int s;
    bearing_t b;
    elev = 0;
    b.flag = 1'b0;
    if (!p.action) begin
      ca = longint'(COEF_A);
      cb = longint'(COEF_B);
      da = longint'(p.phase_a) - longint'(p.phase_ref);
      db = longint'(p.phase_b) - longint'(p.phase_ref);
      dc = longint'(p.phase_c) - longint'(p.phase_ref);
      accx = ca * da - cb * db + ca * dc;
      accy = -ca * da + ca * dc;
      xq = clip32((accx + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      yq = clip32((accy + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      heading = vector_angle(yq, xq);
      prod = longint'(p.bin_index) * adc_rate;
      if (fft_len == 0) f8 = F8_SAT;
      else f8 = (prod << 8) / fft_len;
      if (f8 > F8_SAT) f8 = F8_SAT;
    end else begin
      heading = longint'(p.given_heading);
      xq = longint'(p.given_x);
      yq = longint'(p.given_y);
      f8 = longint'(p.given_frequency) << 8;
    end
    k = (f8 * 64'd287851471 + (64'd1 << 27)) >> 28;
    ax = (xq < 0) ? -xq : xq;
    ay = (yq < 0) ? -yq : yq;
    h = root_floor(ax * ax + ay * ay);
    if (k == 0 || k < h) begin
      b.flag = 1'b1;
    end else begin
      s = 0;
      while ((k >> s) >= (64'd1 << 31)) s++;
      ks = k >> s;
      hs = h >> s;
      r = root_floor((ks - hs) * (ks + hs));
      elev = vector_angle(longint'(hs), longint'(r));
      if (elev < 0) elev = 0;
      if (elev > ELEV_MAX) elev = ELEV_MAX;
    end
    b.heading = heading[14:0];
    b.elevation = elev[12:0];
    b.frequency = f8[31:8];
    return b;
  endfunction

  // inputs change only at rising edges, so sample everything at the falling edge
  always @(negedge clk) begin
    bearing_t e;
    if (out_valid) begin
      bearings_seen++;
      if (out_out_of_range) flagged_seen++;
      if (pending_bearings.size() == 0) begin
        $error("unexpected result: heading %0d", out_heading_out);
        fail_count++;
      end else begin
        e = pending_bearings.pop_front();
        if (out_heading_out !== e.heading) begin
          $error("heading_out: expected %0d got %0d", $signed(e.heading), out_heading_out);
          fail_count++;
        end
        if (out_elevation_out !== e.elevation) begin
          $error("elevation_out: expected %0d got %0d", e.elevation, out_elevation_out);
          fail_count++;
        end
        if (out_frequency_hz !== e.frequency) begin
          $error("frequency_hz: expected %0d got %0d", e.frequency, out_frequency_hz);
          fail_count++;
        end
        if (out_out_of_range !== e.flag) begin
          $error("out_of_range: expected %0d got %0d", e.flag, out_out_of_range);
          fail_count++;
        end
      end
    end
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called at a rising edge; leaves start high unless an idle gap is drawn, so back-to-back requests stay clean
  task automatic send_ping(input ping_t p);
    start <= 1'b1;
    in_action <= p.action;
    in_phase_ref <= p.phase_ref;
    in_phase_a <= p.phase_a;
    in_phase_b <= p.phase_b;
    in_phase_c <= p.phase_c;
    in_bin_index <= p.bin_index;
    in_given_heading <= p.given_heading;
    in_given_x <= p.given_x;
    in_given_y <= p.given_y;
    in_given_frequency <= p.given_frequency;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_bearings.push_back(predict_bearing(p));
    pings_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_bearings();
    start <= 1'b0;
    while (pending_bearings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [23:0] value);
    drain_bearings();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SAMPLE_RATE) adc_rate = value;
    else fft_len = value & 24'h1FFFF;
    cfg_writes++;
  endtask

  function automatic ping_t random_ping();
    ping_t p;
    int sel;
    sel = $urandom_range(5);
    p.action = 1'($urandom_range(1));
    p.phase_ref = 16'($urandom);
    p.bin_index = (sel < 2) ? 16'($urandom) : 16'($urandom_range(255));
    // small phase spreads keep the wavenumber above h, so elevation gets exercised
    if (sel < 2) begin
      p.phase_a = 16'($urandom);
      p.phase_b = 16'($urandom);
      p.phase_c = 16'($urandom);
    end else begin
      p.phase_a = p.phase_ref + $signed(16'($urandom_range(64))) - 16'sd32;
      p.phase_b = p.phase_ref + $signed(16'($urandom_range(64))) - 16'sd32;
      p.phase_c = p.phase_ref + $signed(16'($urandom_range(64))) - 16'sd32;
    end
    p.given_heading = 15'($urandom);
    p.given_frequency = 24'($urandom);
    if (sel < 2) begin
      p.given_x = $urandom;
      p.given_y = $urandom;
    end else begin
      p.given_x = $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
      p.given_y = $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
    end
    return p;
  endfunction

  function automatic ping_t mode0_ping(logic signed [15:0] r, logic signed [15:0] a,
                                       logic signed [15:0] b, logic signed [15:0] c,
                                       logic [15:0] bin);
    ping_t p;
    p = random_ping();
    p.action = 1'b0;
    p.phase_ref = r; p.phase_a = a; p.phase_b = b; p.phase_c = c;
    p.bin_index = bin;
    return p;
  endfunction

  function automatic ping_t mode1_ping(logic signed [14:0] hd, logic signed [31:0] x,
                                       logic signed [31:0] y, logic [23:0] f);
    ping_t p;
    p = random_ping();
    p.action = 1'b1;
    p.given_heading = hd; p.given_x = x; p.given_y = y; p.given_frequency = f;
    return p;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_ping(mode0_ping(0, 0, 0, 0, 0));
    send_ping(mode0_ping(0, 0, 0, 0, 16'hFFFF));
    send_ping(mode0_ping(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'hFFFF));
    send_ping(mode0_ping(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1));
    send_ping(mode0_ping(100, 90, 130, 95, 40));
    send_ping(mode0_ping(100, 120, 60, 110, 200));
    send_ping(mode0_ping(-5, -20, 10, -30, 7));
    send_ping(mode0_ping(0, 5, -3, 0, 16'hFFFF));
    send_ping(mode1_ping(0, 0, 0, 0));
    send_ping(mode1_ping(0, 0, 0, 24'hFFFFFF));
    send_ping(mode1_ping(15'sd12868, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFFFFFF));
    send_ping(mode1_ping(-15'sd12868, -32'sh8000_0000, -32'sh8000_0000, 24'hFFFFFF));
    send_ping(mode1_ping(15'sh3FFF, 32'sh0001_0000, 0, 1500));
    send_ping(mode1_ping(-15'sh4000, 0, 32'sh0001_0000, 100000));
    send_ping(mode1_ping(15'sh2000, -32'sh0000_8000, 32'sh0000_8000, 24000));
    send_ping(mode1_ping(-15'sh2000, -32'sh0000_8000, -32'sh0000_8000, 24000));
    send_ping(mode1_ping(0, 32'sh0040_0000, 0, 1));
    send_ping(mode1_ping(0, 0, 0, 1));
    // hold off until every result is back before resuming
    drain_bearings();
    send_ping(mode1_ping(1, 32'sh0000_0100, -32'sh0000_0100, 50000));
    send_ping(mode0_ping(0, 1, 1, 1, 3));
  endtask

  task automatic test_cfg_extremes();
    logic [23:0] rates [4] = '{24'hFFFFFF, 24'd0, 24'd1, 24'd48000};
    logic [23:0] sizes [4] = '{24'd1, 24'd0, 24'h010000, 24'hFE0003};
    for (int i = 0; i < 4; i++) begin
      write_cfg(CFG_SAMPLE_RATE, rates[i]);
      write_cfg(CFG_FFT_SIZE, sizes[i]);
      idle_pct = 20;
      repeat (10) send_ping(random_ping());
      send_ping(mode0_ping(0, 4, -4, 2, 16'hFFFF));
    end
  endtask

  task automatic test_random_traffic();
    int pcts [4] = '{0, 55, 0, 20};
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_SAMPLE_RATE, (ph % 2) ? 24'($urandom) : 24'($urandom_range(1000, 1000000)));
      write_cfg(CFG_FFT_SIZE, (ph == 3) ? 24'($urandom) : 24'($urandom_range(1, 4096)));
      idle_pct = pcts[ph];
      repeat (140) send_ping(random_ping());
    end
    write_cfg(CFG_SAMPLE_RATE, 24'd500000);
    write_cfg(CFG_FFT_SIZE, 24'd256);
    idle_pct = 20;
    repeat (40) send_ping(random_ping());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cfg_extremes();
    test_random_traffic();
    drain_bearings();
    $display("covered %0d pings (%0d flagged results) in both modes, %0d register writes",
             pings_sent, flagged_seen, cfg_writes);
    $display("checked %0d results across idle mixes of 0/20/55 percent", bearings_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
